@@ rtl/button_debounce_chord_longpress_top_assert.svh @@
// assertion macros used by the checker module
`ifndef BUTTON_DEBOUNCE_CHORD_LONGPRESS_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_CHORD_LONGPRESS_TOP_ASSERT_SVH

// property checked only outside reset
`define BDCL_ASSERT_ACTIVE(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bdcl check failed");

// property checked at every edge, reset included
`define BDCL_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("bdcl check failed");

`endif

@@ rtl/bdcl_pkg.sv @@
package bdcl_pkg;

   // lane counts: three buttons plus the encoder switch
   localparam int NUM_BUTTONS = 3;
   localparam int NUM_PINS    = 4;

   // debounce history length default
   localparam int HISTORY_BITS_DEFAULT = 8;

   // hold counter and threshold
   localparam int HOLD_BITS = 8;
   localparam logic [HOLD_BITS-1:0] HOLD_MAX         = 8'hFF;
   localparam logic [HOLD_BITS-1:0] LONG_PRESS_RESET = 8'd200;

   // one scan tick of raw pin levels, 0 means pushed
   typedef struct packed {
      logic pin_button_one;
      logic pin_button_two;
      logic pin_button_three;
      logic pin_encoder_switch;
   } req_type;

   // one result per scan tick
   typedef struct packed {
      logic [3:0] pressed_mask;
      logic       channel_valid;
      logic [2:0] channel_chord;
      logic [2:0] speed_mask;
   } rsp_type;

   // what one debounce lane tells the merge stage
   typedef struct packed {
      logic pressed_prev;
      logic pressed_next;
      logic rise;
   } lane_status_type;

endpackage

@@ rtl/bdcl_lane.sv @@
module bdcl_lane #(
   parameter int HISTORY_BITS = bdcl_pkg::HISTORY_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      pin_level,
   output bdcl_pkg::lane_status_type status
);

   logic [HISTORY_BITS-1:0] history_ff;
   logic [HISTORY_BITS-1:0] history_in;
   logic                    pressed_ff;
   logic                    pressed_in;
   logic                    all_ones;
   logic                    all_zeros;

   // shift in a one when the pin is pulled low
   assign history_in = {history_ff[HISTORY_BITS-2:0], ~pin_level};
   assign all_ones   = &history_in;
   assign all_zeros  = ~|history_in;

   // debounced state flips only on a full history
   assign pressed_in = pressed_ff ? ~all_zeros : all_ones;

   assign status.pressed_prev = pressed_ff;
   assign status.pressed_next = pressed_in;
   assign status.rise         = ~pressed_ff & all_ones;

   // lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         pressed_ff <= 1'b0;
      end else if (accept) begin
         history_ff <= history_in;
         pressed_ff <= pressed_in;
      end
   end

endmodule

@@ rtl/bdcl_merge.sv @@
module bdcl_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [bdcl_pkg::HOLD_BITS-1:0]        threshold,
   input  bdcl_pkg::lane_status_type             lane_status [bdcl_pkg::NUM_PINS],
   output bdcl_pkg::rsp_type                     result
);

   localparam int NB = bdcl_pkg::NUM_BUTTONS;
   localparam int NP = bdcl_pkg::NUM_PINS;

   logic [bdcl_pkg::HOLD_BITS-1:0] hold_ff   [NB];
   logic [bdcl_pkg::HOLD_BITS-1:0] hold_in   [NB];
   logic [bdcl_pkg::HOLD_BITS-1:0] step_base [NB];
   logic [NB-1:0] rise_vec;
   logic [NB-1:0] prev_vec;
   logic [NP-1:0] next_vec;
   logic [NB-1:0] later_rise;
   logic [NB-1:0] earlier_rise;
   logic [NB-1:0] fire_vec;
   logic [NB-1:0] advance_vec;
   logic [NB-1:0] chord_raw;
   logic          any_rise;

   // gather lane flags
   always_comb begin
      for (int i = 0; i < NP; i++) begin
         next_vec[i] = lane_status[i].pressed_next;
      end
      for (int i = 0; i < NB; i++) begin
         rise_vec[i] = lane_status[i].rise;
         prev_vec[i] = lane_status[i].pressed_prev;
      end
   end

   // presses handled before and after each button in scan order
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         later_rise[i]   = 1'b0;
         earlier_rise[i] = 1'b0;
         for (int j = 0; j < NB; j++) begin
            if (j > i) later_rise[i] = later_rise[i] | rise_vec[j];
            if (j < i) earlier_rise[i] = earlier_rise[i] | rise_vec[j];
         end
      end
   end

   assign any_rise = |rise_vec;

   // per-button hold counter step, chord bit
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         // an earlier press clears this counter before it steps
         step_base[i]   = earlier_rise[i] ? '0 : hold_ff[i];
         fire_vec[i]    = prev_vec[i] && (step_base[i] == threshold) &&
                          (threshold != bdcl_pkg::HOLD_MAX);
         advance_vec[i] = prev_vec[i] && ((step_base[i] < threshold) || fire_vec[i]);
         if (later_rise[i] || rise_vec[i]) begin
            hold_in[i] = '0;
         end else if (advance_vec[i]) begin
            hold_in[i] = step_base[i] + 1'b1;
         end else begin
            hold_in[i] = step_base[i];
         end
         // buttons up to the last press show updated state
         chord_raw[i] = (later_rise[i] || rise_vec[i]) ? next_vec[i] : prev_vec[i];
      end
   end

   assign result.pressed_mask  = next_vec;
   assign result.channel_valid = any_rise;
   assign result.channel_chord = any_rise ? chord_raw : '0;
   assign result.speed_mask    = fire_vec;

   // hold counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) hold_ff[i] <= '0;
      end else if (accept) begin
         for (int i = 0; i < NB; i++) hold_ff[i] <= hold_in[i];
      end
   end

endmodule

@@ rtl/button_debounce_chord_longpress_top.sv @@
// Debouncer for three push buttons and an encoder switch with chord and
// long-press reporting.
// Request channel: req_valid / req_stall / req_payload, one scan tick of four
// raw active-low pin levels per request.
// Response channel: rsp_valid / rsp_stall / rsp_payload, exactly one response
// per request: debounced states, newly-pressed chord event, speed events.
// Config: csr_wr_en / csr_wr_data load the long-press threshold; write only
// while no request is in flight.
// Latency: the response is valid on the cycle after the request is taken.
// Throughput: one request per cycle unless req_stall; four debounce lanes and
// the merge are combinational; the single output register is the only buffer.
// Stall: while a response waits under rsp_stall, req_stall is raised; the
// output register is refilled on the same edge a waiting response is taken.
// Reset: histories, debounced states and hold counters clear, the threshold
// returns to 200, and no response is pending.
module button_debounce_chord_longpress_top #(
   parameter int HISTORY_BITS = bdcl_pkg::HISTORY_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bdcl_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bdcl_pkg::rsp_type              rsp_payload,
   input  logic                           csr_wr_en,
   input  logic [bdcl_pkg::HOLD_BITS-1:0] csr_wr_data
);

   logic [bdcl_pkg::HOLD_BITS-1:0] threshold_ff;
   logic [bdcl_pkg::NUM_PINS-1:0]  pin_vec;
   bdcl_pkg::lane_status_type      lane_status [bdcl_pkg::NUM_PINS];
   bdcl_pkg::rsp_type              result;
   bdcl_pkg::rsp_type              rsp_payload_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           accept;

   // handshake
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // lane 0..2 buttons, lane 3 encoder switch
   assign pin_vec = {req_payload.pin_encoder_switch, req_payload.pin_button_three,
                     req_payload.pin_button_two, req_payload.pin_button_one};

   // debounce lanes
   for (genvar g = 0; g < bdcl_pkg::NUM_PINS; g++) begin : g_lane
      bdcl_lane #(
         .HISTORY_BITS (HISTORY_BITS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .accept    (accept),
         .pin_level (pin_vec[g]),
         .status    (lane_status[g])
      );
   end

   // chord and long-press merge
   bdcl_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .threshold   (threshold_ff),
      .lane_status (lane_status),
      .result      (result)
   );

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= bdcl_pkg::LONG_PRESS_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/bdcl_assert_check.sv @@
`include "button_debounce_chord_longpress_top_assert.svh"

module bdcl_assert_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bdcl_pkg::rsp_type rsp_payload
);

   // nothing pending right after reset
   `BDCL_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // a taken request shows its response on the next cycle
   `BDCL_ASSERT_ACTIVE(a_one_cycle, clock, reset, req_valid && !req_stall |=> rsp_valid)

   // a stalled response holds
   `BDCL_ASSERT_ACTIVE(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // no chord without a press event
   `BDCL_ASSERT_ACTIVE(a_chord_idle, clock, reset, rsp_valid && !rsp_payload.channel_valid |-> rsp_payload.channel_chord == 3'd0)

   // the newly pressed button is always in the chord
   `BDCL_ASSERT_ACTIVE(a_chord_set, clock, reset, rsp_valid && rsp_payload.channel_valid |-> rsp_payload.channel_chord != 3'd0)

endmodule

bind button_debounce_chord_longpress_top bdcl_assert_check u_bdcl_assert_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
